// ===== hdl/sha512_pkg.sv =====
// SHA-512 hasher package: queue entry type, round constants and initial chaining values.
// No dependencies; imported by every module of the hasher.
`timescale 1ns / 1ps

package sha512_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ROUND_LAST      = 79;
    localparam logic [6:0] LEN_POS = 7'd112;
    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    typedef struct packed {
        logic [63:0] word;
        logic        final_blk;
    } sha512_word_t;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        unique case (t)
            7'd0:  k = 64'h428A2F98D728AE22;
            7'd1:  k = 64'h7137449123EF65CD;
            7'd2:  k = 64'hB5C0FBCFEC4D3B2F;
            7'd3:  k = 64'hE9B5DBA58189DBBC;
            7'd4:  k = 64'h3956C25BF348B538;
            7'd5:  k = 64'h59F111F1B605D019;
            7'd6:  k = 64'h923F82A4AF194F9B;
            7'd7:  k = 64'hAB1C5ED5DA6D8118;
            7'd8:  k = 64'hD807AA98A3030242;
            7'd9:  k = 64'h12835B0145706FBE;
            7'd10: k = 64'h243185BE4EE4B28C;
            7'd11: k = 64'h550C7DC3D5FFB4E2;
            7'd12: k = 64'h72BE5D74F27B896F;
            7'd13: k = 64'h80DEB1FE3B1696B1;
            7'd14: k = 64'h9BDC06A725C71235;
            7'd15: k = 64'hC19BF174CF692694;
            7'd16: k = 64'hE49B69C19EF14AD2;
            7'd17: k = 64'hEFBE4786384F25E3;
            7'd18: k = 64'h0FC19DC68B8CD5B5;
            7'd19: k = 64'h240CA1CC77AC9C65;
            7'd20: k = 64'h2DE92C6F592B0275;
            7'd21: k = 64'h4A7484AA6EA6E483;
            7'd22: k = 64'h5CB0A9DCBD41FBD4;
            7'd23: k = 64'h76F988DA831153B5;
            7'd24: k = 64'h983E5152EE66DFAB;
            7'd25: k = 64'hA831C66D2DB43210;
            7'd26: k = 64'hB00327C898FB213F;
            7'd27: k = 64'hBF597FC7BEEF0EE4;
            7'd28: k = 64'hC6E00BF33DA88FC2;
            7'd29: k = 64'hD5A79147930AA725;
            7'd30: k = 64'h06CA6351E003826F;
            7'd31: k = 64'h142929670A0E6E70;
            7'd32: k = 64'h27B70A8546D22FFC;
            7'd33: k = 64'h2E1B21385C26C926;
            7'd34: k = 64'h4D2C6DFC5AC42AED;
            7'd35: k = 64'h53380D139D95B3DF;
            7'd36: k = 64'h650A73548BAF63DE;
            7'd37: k = 64'h766A0ABB3C77B2A8;
            7'd38: k = 64'h81C2C92E47EDAEE6;
            7'd39: k = 64'h92722C851482353B;
            7'd40: k = 64'hA2BFE8A14CF10364;
            7'd41: k = 64'hA81A664BBC423001;
            7'd42: k = 64'hC24B8B70D0F89791;
            7'd43: k = 64'hC76C51A30654BE30;
            7'd44: k = 64'hD192E819D6EF5218;
            7'd45: k = 64'hD69906245565A910;
            7'd46: k = 64'hF40E35855771202A;
            7'd47: k = 64'h106AA07032BBD1B8;
            7'd48: k = 64'h19A4C116B8D2D0C8;
            7'd49: k = 64'h1E376C085141AB53;
            7'd50: k = 64'h2748774CDF8EEB99;
            7'd51: k = 64'h34B0BCB5E19B48A8;
            7'd52: k = 64'h391C0CB3C5C95A63;
            7'd53: k = 64'h4ED8AA4AE3418ACB;
            7'd54: k = 64'h5B9CCA4F7763E373;
            7'd55: k = 64'h682E6FF3D6B2B8A3;
            7'd56: k = 64'h748F82EE5DEFB2FC;
            7'd57: k = 64'h78A5636F43172F60;
            7'd58: k = 64'h84C87814A1F0AB72;
            7'd59: k = 64'h8CC702081A6439EC;
            7'd60: k = 64'h90BEFFFA23631E28;
            7'd61: k = 64'hA4506CEBDE82BDE9;
            7'd62: k = 64'hBEF9A3F7B2C67915;
            7'd63: k = 64'hC67178F2E372532B;
            7'd64: k = 64'hCA273ECEEA26619C;
            7'd65: k = 64'hD186B8C721C0C207;
            7'd66: k = 64'hEADA7DD6CDE0EB1E;
            7'd67: k = 64'hF57D4F7FEE6ED178;
            7'd68: k = 64'h06F067AA72176FBA;
            7'd69: k = 64'h0A637DC5A2C898A6;
            7'd70: k = 64'h113F9804BEF90DAE;
            7'd71: k = 64'h1B710B35131C471B;
            7'd72: k = 64'h28DB77F523047D84;
            7'd73: k = 64'h32CAAB7B40C72493;
            7'd74: k = 64'h3C9EBE0A15C9BEBC;
            7'd75: k = 64'h431D67C49C100D4C;
            7'd76: k = 64'h4CC5D4BECB3E42B6;
            7'd77: k = 64'h597F299CFC657E2A;
            7'd78: k = 64'h5FCB6FAB3AD6FAEC;
            7'd79: k = 64'h6C44198C4A475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] init_chain(input logic [2:0] i);
        logic [63:0] h;
        unique case (i)
            3'd0: h = 64'h6A09E667F3BCC908;
            3'd1: h = 64'hBB67AE8584CAA73B;
            3'd2: h = 64'h3C6EF372FE94F82B;
            3'd3: h = 64'hA54FF53A5F1D36F1;
            3'd4: h = 64'h510E527FADE682D1;
            3'd5: h = 64'h9B05688C2B3E6C1F;
            3'd6: h = 64'h1F83D9ABFB41BD6B;
            default: h = 64'h5BE0CD19137E2179;
        endcase
        return h;
    endfunction

endpackage

// ===== hdl/sha512_front.sv =====
// SHA-512 front end: takes message bytes, packs them into 64-bit words and pads on finish.
// Depends on sha512_pkg; feeds sha512_queue.
`timescale 1ns / 1ps

module sha512_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic [7:0]               data_byte,
    output logic                     push,
    output sha512_pkg::sha512_word_t push_entry,
    input  logic                     q_full
);
    import sha512_pkg::*;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_LEN
    } front_state_t;

    front_state_t state_reg;
    logic [6:0]   pos_reg;
    logic [63:0]  count_reg;
    logic [63:0]  bits_reg;
    logic [3:0]   len_idx_reg;
    logic [55:0]  pack_reg;
    logic         put;
    logic [7:0]   put_byte;

    assign in_ready = (state_reg == ST_ACCEPT) && !q_full;

    always_comb
    begin
        put      = 1'b0;
        put_byte = 8'h00;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                put      = in_valid && in_ready && !operation;
                put_byte = data_byte;
            end
            ST_PAD_MARK:
            begin
                put      = !q_full;
                put_byte = PAD_MARK_BYTE;
            end
            ST_PAD_ZERO:
            begin
                put = !q_full && (pos_reg != LEN_POS);
            end
            ST_LEN:
            begin
                put      = !q_full;
                put_byte = len_idx_reg[3] ? bits_reg[63:56] : 8'h00;
            end
            default:
            begin
                put = 1'b0;
            end
        endcase
    end

    assign push                 = put && (pos_reg[2:0] == 3'd7);
    assign push_entry.word      = {pack_reg, put_byte};
    assign push_entry.final_blk = (state_reg == ST_LEN) && (len_idx_reg == 4'd15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCEPT;
            pos_reg     <= '0;
            count_reg   <= '0;
            len_idx_reg <= '0;
        end
        else
        begin
            if (put)
            begin
                pos_reg <= pos_reg + 7'd1;
            end
            unique case (state_reg)
                ST_ACCEPT:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (operation)
                        begin
                            state_reg <= ST_PAD_MARK;
                        end
                        else
                        begin
                            count_reg <= count_reg + 64'd1;
                        end
                    end
                end
                ST_PAD_MARK:
                begin
                    if (put)
                    begin
                        state_reg <= ST_PAD_ZERO;
                    end
                end
                ST_PAD_ZERO:
                begin
                    if (pos_reg == LEN_POS)
                    begin
                        state_reg   <= ST_LEN;
                        len_idx_reg <= '0;
                    end
                end
                ST_LEN:
                begin
                    if (put)
                    begin
                        len_idx_reg <= len_idx_reg + 4'd1;
                        if (len_idx_reg == 4'd15)
                        begin
                            state_reg <= ST_ACCEPT;
                            count_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_ACCEPT;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            pack_reg <= {pack_reg[47:0], put_byte};
        end
        if (state_reg == ST_ACCEPT && in_valid && in_ready && operation)
        begin
            bits_reg <= {count_reg[60:0], 3'b000};
        end
        else if (state_reg == ST_LEN && put && len_idx_reg[3])
        begin
            bits_reg <= {bits_reg[55:0], 8'h00};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("word pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_entry.final_blk && push |-> pos_reg == 7'd127)
        else $error("final word not at the end of a block");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN) && put && (len_idx_reg == 4'd15) |=> pos_reg == 7'd0)
        else $error("padding did not end on a block boundary");

endmodule

// ===== hdl/sha512_queue.sv =====
// SHA-512 word queue: short FIFO of packed message words between front and core.
// Depends on sha512_pkg.
`timescale 1ns / 1ps

module sha512_queue #(
    parameter int QUEUE_DEPTH = sha512_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  sha512_pkg::sha512_word_t push_entry,
    output logic                     full,
    input  logic                     pop,
    output logic                     not_empty,
    output sha512_pkg::sha512_word_t head
);
    import sha512_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    sha512_word_t    mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CntW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== hdl/sha512_core.sv =====
// SHA-512 compression core: loads 16 words, runs 80 rounds, folds into the chain, emits digest.
// Depends on sha512_pkg; fed by sha512_queue.
`timescale 1ns / 1ps

module sha512_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_not_empty,
    input  sha512_pkg::sha512_word_t q_head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [63:0]              digest_word,
    output logic [2:0]               word_index,
    output logic                     last_word
);
    import sha512_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } core_state_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    core_state_t state_reg;
    logic [3:0]  wcnt_reg;
    logic [6:0]  round_reg;
    logic        final_reg;
    logic        done_reg;
    logic [2:0]  out_idx_reg;
    logic [63:0] chain_reg [8];
    logic [63:0] w_reg [16];
    logic [63:0] v_reg [8];
    logic        out_valid_reg;
    logic [63:0] out_word_reg;
    logic [2:0]  out_index_reg;
    logic        out_last_reg;

    logic [63:0] big0;
    logic [63:0] big1;
    logic [63:0] choose;
    logic [63:0] major;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] sched_s0;
    logic [63:0] sched_s1;
    logic [63:0] w_new;
    logic        slot_free;

    assign pop       = (state_reg == ST_LOAD) && q_not_empty;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        big1     = rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41);
        choose   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1       = v_reg[7] + big1 + choose + round_k(round_reg) + w_reg[0];
        big0     = rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39);
        major    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2       = big0 + major;
        sched_s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        sched_s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new    = w_reg[0] + sched_s0 + w_reg[9] + sched_s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            wcnt_reg      <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            done_reg      <= 1'b0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_chain(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (pop)
                    begin
                        wcnt_reg <= wcnt_reg + 4'd1;
                        if (q_head.final_blk)
                        begin
                            final_reg <= 1'b1;
                        end
                        if (wcnt_reg == 4'd15)
                        begin
                            state_reg <= ST_ROUND;
                            round_reg <= '0;
                        end
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'(ROUND_LAST))
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                    if (final_reg)
                    begin
                        state_reg   <= ST_OUT;
                        out_idx_reg <= '0;
                        done_reg    <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_OUT:
                begin
                    if (slot_free)
                    begin
                        if (!done_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_word_reg  <= chain_reg[out_idx_reg];
                            out_index_reg <= out_idx_reg;
                            out_last_reg  <= (out_idx_reg == 3'd7);
                            out_idx_reg   <= out_idx_reg + 3'd1;
                            done_reg      <= (out_idx_reg == 3'd7);
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            final_reg     <= 1'b0;
                            state_reg     <= ST_LOAD;
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= init_chain(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && pop)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= q_head.word;
            if (wcnt_reg == 4'd15)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= chain_reg[i];
                end
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= v_reg[5];
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= v_reg[3] + t1;
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= v_reg[1];
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1 + t2;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_index_reg;
    assign last_word   = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_OUT)
        else $error("digest word shown outside output phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_index_reg == 3'd7)
        else $error("last mark on a word other than the eighth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) && final_reg |=> state_reg == ST_OUT)
        else $error("final block did not lead to digest output");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> wcnt_reg == 4'd0)
        else $error("rounds started with a partial block");

endmodule

// ===== hdl/sha512_byte_stream_hasher.sv =====
// SHA-512 byte-stream hasher top level: front end, word queue and compression core.
// Depends on sha512_pkg, sha512_front, sha512_queue and sha512_core.
//
//  channel  | dir | tdata                                   | tuser       | tlast
//  s_axis   | in  | [7:0] data_byte                         | [0] operation | -
//  m_axis   | out | [63:0] digest_word, [66:64] word_index  | -           | last_word
//
// Bytes are taken one a cycle unless the input stalls; words of eight bytes go through a queue of QUEUE_DEPTH words.
// In the core a block is loaded word by word, run through its rounds and added into the chain, so a
// steady stream keeps one byte per cycle while the queue absorbs words during the rounds.
// A finish item pads one byte a cycle while the queue has room, then the core emits eight words.
// Reset is asynchronous and clears control state and the chain; there is no clearing pass.
// The input stalls only while the queue is full or padding runs; output stalls back up the queue.
`timescale 1ns / 1ps

module sha512_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = sha512_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] digest_word, [66:64] word_index, zero fill
    output logic        m_axis_tlast
);
    import sha512_pkg::*;

    logic         push;
    sha512_word_t push_entry;
    logic         q_full;
    logic         pop;
    logic         q_not_empty;
    sha512_word_t q_head;
    logic [63:0]  digest_word;
    logic [2:0]   word_index;

    sha512_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .operation  (s_axis_tuser),
        .data_byte  (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    sha512_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    sha512_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, word_index, digest_word};

endmodule

// ===== test/tb_sha512_byte_stream_hasher.sv =====
// Self-checking testbench for sha512_byte_stream_hasher: streams message bytes and finish
// transfers, predicts every digest word with its own SHA-512 model and checks the output.
// Depends on the hasher RTL only; needs no files or arguments.
`timescale 1ns / 1ps

module tb_sha512_byte_stream_hasher;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } hash_op_t;

    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE
    } load_phase_t;

    typedef struct {
        hash_op_t   operation;
        logic [7:0] data_byte;
    } stream_item_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [6:0] LENGTH_FIELD_POS = 7'd112;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [63:0] round_k_tab [0:79] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    logic [63:0] start_chain [0:7] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    logic [63:0] hash_chain [0:7];
    logic [7:0]  msg_block [0:127];
    logic [63:0] msg_byte_count;
    logic [6:0]  block_fill;

    stream_item_t pending_items [$];
    digest_word_t digest_words_due [$];

    int total_items;
    int accepted_items;
    int bytes_hashed;
    int messages_closed;
    int words_checked;
    int mismatch_count;
    int cycle_count;

    sha512_byte_stream_hasher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_chain[i] = start_chain[i];
        end
        msg_byte_count = 64'd0;
        block_fill = 7'd0;
    endtask

    task automatic compress_into_chain();
        logic [63:0] w [0:79];
        logic [63:0] a, b, c, d, e, f, g, h;
        logic [63:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = 64'd0;
            for (int i = 0; i < 8; i++)
            begin
                w[t] = {w[t][55:0], msg_block[t * 8 + i]};
            end
        end
        for (int t = 16; t < 80; t++)
        begin
            s0 = rotr64(w[t - 15], 1) ^ rotr64(w[t - 15], 8) ^ (w[t - 15] >> 7);
            s1 = rotr64(w[t - 2], 19) ^ rotr64(w[t - 2], 61) ^ (w[t - 2] >> 6);
            w[t] = w[t - 16] + s0 + w[t - 7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3],
                                    hash_chain[4], hash_chain[5], hash_chain[6], hash_chain[7]};
        for (int t = 0; t < 80; t++)
        begin
            t1 = h + (rotr64(e, 14) ^ rotr64(e, 18) ^ rotr64(e, 41)) + ((e & f) ^ (~e & g))
                 + round_k_tab[t] + w[t];
            t2 = (rotr64(a, 28) ^ rotr64(a, 34) ^ rotr64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
        hash_chain[5] += f;
        hash_chain[6] += g;
        hash_chain[7] += h;
    endtask

    task automatic load_block_byte(input logic [7:0] value);
        msg_block[block_fill] = value;
        block_fill = block_fill + 7'd1;
        if (block_fill == 7'd0)
        begin
            compress_into_chain();
        end
    endtask

    task automatic predict_transfer(input hash_op_t op, input logic [7:0] value);
        logic [63:0] bit_length;
        digest_word_t dw;
        if (op == OP_ABSORB)
        begin
            msg_byte_count = msg_byte_count + 64'd1;
            bytes_hashed++;
            load_block_byte(value);
        end
        else
        begin
            bit_length = msg_byte_count << 3;
            load_block_byte(8'h80);
            while (block_fill != LENGTH_FIELD_POS)
            begin
                load_block_byte(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                load_block_byte(8'h00);
            end
            for (int i = 7; i >= 0; i--)
            begin
                load_block_byte(bit_length[i * 8 +: 8]);
            end
            for (int i = 0; i < 8; i++)
            begin
                dw.word = hash_chain[i];
                dw.index = 3'(i);
                dw.last = (i == 7);
                digest_words_due.insert(digest_words_due.size(), dw);
            end
            messages_closed++;
            restart_hash();
        end
    endtask

    function automatic load_phase_t current_phase();
        int p;
        if (total_items == 0)
        begin
            return PH_STEADY;
        end
        p = (accepted_items * 4) / total_items;
        if (p > 3)
        begin
            p = 3;
        end
        return load_phase_t'(p);
    endfunction

    function automatic int sender_idle_pct();
        case (current_phase())
            PH_SENDER_IDLE: return 73;
            PH_BOTH_IDLE:   return 32;
            default:        return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (current_phase())
            PH_SINK_STALL: return 73;
            PH_BOTH_IDLE:  return 32;
            default:       return 0;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("tb: mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    task automatic queue_item(input hash_op_t op, input logic [7:0] value);
        stream_item_t it;
        it.operation = op;
        it.data_byte = value;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            queue_item(OP_ABSORB, 8'($urandom_range(255)));
        end
        queue_item(OP_FINISH, 8'($urandom_range(255)));
    endtask

    // Drive the input side; predict each transfer as it is taken.
    always @(posedge clk or negedge rst_n)
    begin : feed_proc
        stream_item_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            s_axis_tuser <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_transfer(hash_op_t'(s_axis_tuser), s_axis_tdata);
                accepted_items++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    nxt = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.data_byte;
                    s_axis_tuser <= nxt.operation;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each digest transfer against the oldest word due.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        digest_word_t due;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_words_due.size() == 0)
                begin
                    note_mismatch("word with nothing due", 64'd0, m_axis_tdata[63:0]);
                end
                else
                begin
                    due = digest_words_due.pop_front();
                    words_checked++;
                    if (m_axis_tdata[63:0] !== due.word)
                    begin
                        note_mismatch("digest_word", due.word, m_axis_tdata[63:0]);
                    end
                    if (m_axis_tdata[66:64] !== due.index)
                    begin
                        note_mismatch("word_index", 64'(due.index), 64'(m_axis_tdata[66:64]));
                    end
                    if (m_axis_tlast !== due.last)
                    begin
                        note_mismatch("last_word", 64'(due.last), 64'(m_axis_tlast));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timed out with %0d words still due", digest_words_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int random_items;
        int msg_idx;
        int len;

        restart_hash();

        // Directed: empty messages back to back, byte extremes, a known string, a full word.
        queue_item(OP_FINISH, 8'hFF);
        queue_item(OP_FINISH, 8'h00);
        queue_item(OP_ABSORB, 8'h00);
        queue_item(OP_ABSORB, 8'hFF);
        queue_item(OP_FINISH, 8'h5A);
        queue_item(OP_ABSORB, 8'h61);
        queue_item(OP_ABSORB, 8'h62);
        queue_item(OP_ABSORB, 8'h63);
        queue_item(OP_FINISH, 8'hA5);
        queue_item(OP_ABSORB, 8'h55);
        queue_item(OP_ABSORB, 8'hAA);
        queue_item(OP_ABSORB, 8'h01);
        queue_item(OP_ABSORB, 8'h80);
        queue_item(OP_ABSORB, 8'h7F);
        queue_item(OP_FINISH, 8'h00);
        queue_message(8);

        // Random: a block nearly full at finish, then short messages.
        random_items = 0;
        msg_idx = 0;
        while (random_items < 185)
        begin
            if (msg_idx == 0)
            begin
                len = $urandom_range(127, 112);
            end
            else if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(40, 13);
            end
            else
            begin
                len = $urandom_range(12, 0);
            end
            queue_message(len);
            random_items += len + 1;
            msg_idx++;
        end
        total_items = pending_items.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (digest_words_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d transfers in, %0d message bytes over %0d messages",
                 accepted_items, bytes_hashed, messages_closed);
        $display("tb: %0d digest words compared, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sha512_pkg.sv
hdl/sha512_front.sv
hdl/sha512_queue.sv
hdl/sha512_core.sv
hdl/sha512_byte_stream_hasher.sv
test/tb_sha512_byte_stream_hasher.sv
